FILE: rtl/core/bounded_deque_with_erase_assert.svh
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DEQUE_WITH_ERASE_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_ERASE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define BDQE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque check failed");

// Next-cycle implication, disabled while in reset.
`define BDQE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

FILE: rtl/core/bdqe_pkg.sv
// Types and codes for the bounded deque with erase.
package bdqe_pkg;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_POP_FRONT  = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_ERASE      = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;
    localparam logic [2:0] OP_READOUT    = 3'd6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_RDEMPTY  = 3'd4;

    typedef logic [2:0] t_cell_act;

    localparam t_cell_act CELL_HOLD  = 3'd0;
    localparam t_cell_act CELL_PUSHF = 3'd1;
    localparam t_cell_act CELL_PUSHB = 3'd2;
    localparam t_cell_act CELL_POPF  = 3'd3;
    localparam t_cell_act CELL_ERASE = 3'd4;
    localparam t_cell_act CELL_ROT   = 3'd5;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic               is_element;
        logic signed [31:0] element;
        logic               last;
        logic [2:0]         status;
        logic [4:0]         occupancy;
    } t_out;

endpackage

FILE: rtl/core/bdqe_cell.sv
// One storage cell of the deque chain: holds one entry, shifts with its neighbors.
module bdqe_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int W   = 32
) (
    input  logic                i_clk,
    input  bdqe_pkg::t_cell_act i_act,
    input  logic [CW-1:0]       i_count,
    input  logic [W-1:0]        i_value,
    input  logic [W-1:0]        i_left,
    input  logic [W-1:0]        i_right,
    input  logic [W-1:0]        i_head,
    input  logic                i_found,
    output logic                o_found,
    output logic [W-1:0]        o_data
);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;
    logic         w_used;
    logic         w_tail;

    assign w_used  = i_count > CW'(IDX);
    assign w_tail  = i_count == CW'(IDX + 1);
    // first-match chain: set from the first matching cell onward
    assign o_found = i_found | (w_used && (r_data == i_value));
    assign o_data  = r_data;

    always_comb begin
        n_data = r_data;
        unique case (i_act)
            bdqe_pkg::CELL_HOLD:  n_data = r_data;
            bdqe_pkg::CELL_PUSHF: n_data = (IDX == 0) ? i_value : i_left;
            bdqe_pkg::CELL_PUSHB: n_data = (i_count == CW'(IDX)) ? i_value : r_data;
            bdqe_pkg::CELL_POPF:  n_data = i_right;
            bdqe_pkg::CELL_ERASE: n_data = o_found ? i_right : r_data;
            bdqe_pkg::CELL_ROT:   n_data = w_tail ? i_head : i_right;
            default:              n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

endmodule

FILE: rtl/core/bounded_deque_with_erase.sv
// Top level of the bounded deque with erase-by-value.
// Bounded deque of up to CAPACITY words kept in a chain of cells, entry 0 at the front.
// Push/pop at either end, erase of the first entry equal to value, and clear each return
// one status item carrying the new count. A readout streams the entries front to back,
// one item per cycle while the receiver takes them, by rotating the chain once around,
// and holds the input side until its last entry is emitted; an empty readout returns one
// status item. A new item is taken only when the output register is empty or its result
// leaves in the same cycle, so every cycle the receiver stalls holds the input as well.
module bounded_deque_with_erase #(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  bdqe_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output bdqe_pkg::t_out o_out
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic [WORD_BITS-1:0] w_data [CAPACITY];
    logic [CAPACITY:0]    w_found;
    logic [31:0]          w_vbits;
    logic [WORD_BITS-1:0] w_value;

    logic                 r_busy,      n_busy;
    logic [CW-1:0]        r_count,     n_count;
    logic [CW-1:0]        r_rd_idx,    n_rd_idx;
    logic                 r_out_valid;
    bdqe_pkg::t_out       r_out,       n_out;

    logic                 w_accept;
    logic                 w_slot;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_load;
    logic                 w_step;
    logic                 w_step_last;
    logic [CW-1:0]        w_step_idx;
    logic [CW-1:0]        w_step_nxt;
    bdqe_pkg::t_cell_act  w_act;

    assign w_vbits  = i_in.value;
    assign w_value  = WORD_BITS'(w_vbits);
    assign w_slot   = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_busy && w_slot;
    assign w_accept = i_in_valid && o_in_ready;
    assign w_full   = r_count == CW'(CAPACITY);
    assign w_empty  = r_count == '0;

    assign w_found[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [WORD_BITS-1:0] w_left;
        logic [WORD_BITS-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = w_data[0];
        end else begin : g_mid
            assign w_left = w_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_data[g];
        end else begin : g_inner
            assign w_right = w_data[g+1];
        end
        bdqe_cell #(
            .IDX (g),
            .CW  (CW),
            .W   (WORD_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_act   (w_act),
            .i_count (r_count),
            .i_value (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_data[0]),
            .i_found (w_found[g]),
            .o_found (w_found[g+1]),
            .o_data  (w_data[g])
        );
    end

    assign w_step_nxt  = w_step_idx + 1'b1;
    assign w_step_last = w_step_nxt == r_count;

    always_comb begin
        w_act      = bdqe_pkg::CELL_HOLD;
        n_count    = r_count;
        n_busy     = r_busy;
        n_rd_idx   = r_rd_idx;
        w_load     = 1'b0;
        w_step     = 1'b0;
        w_step_idx = r_rd_idx;
        n_out      = '0;
        n_out.last = 1'b1;
        n_out.status = bdqe_pkg::ST_OK;

        if (r_busy) begin
            w_step = w_slot;
        end else if (w_accept) begin
            w_load = 1'b1;
            unique case (i_in.op)
                bdqe_pkg::OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_out.status = bdqe_pkg::ST_FULL;
                    end else begin
                        w_act   = bdqe_pkg::CELL_PUSHF;
                        n_count = r_count + 1'b1;
                    end
                end
                bdqe_pkg::OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_out.status = bdqe_pkg::ST_EMPTY;
                    end else begin
                        w_act   = bdqe_pkg::CELL_POPF;
                        n_count = r_count - 1'b1;
                    end
                end
                bdqe_pkg::OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_out.status = bdqe_pkg::ST_FULL;
                    end else begin
                        w_act   = bdqe_pkg::CELL_PUSHB;
                        n_count = r_count + 1'b1;
                    end
                end
                bdqe_pkg::OP_POP_BACK: begin
                    if (w_empty) begin
                        n_out.status = bdqe_pkg::ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                bdqe_pkg::OP_ERASE: begin
                    if (w_found[CAPACITY]) begin
                        w_act   = bdqe_pkg::CELL_ERASE;
                        n_count = r_count - 1'b1;
                    end else begin
                        n_out.status = bdqe_pkg::ST_NOTFOUND;
                    end
                end
                bdqe_pkg::OP_CLEAR: begin
                    n_count = '0;
                end
                bdqe_pkg::OP_READOUT: begin
                    if (w_empty) begin
                        n_out.status = bdqe_pkg::ST_RDEMPTY;
                    end else begin
                        w_step     = 1'b1;
                        w_step_idx = '0;
                    end
                end
                default: ;
            endcase
        end

        // readout: emit the front entry and rotate the chain by one
        if (w_step) begin
            w_act            = bdqe_pkg::CELL_ROT;
            w_load           = 1'b1;
            n_out.is_element = 1'b1;
            n_out.element    = 32'(w_data[0]);
            n_out.last       = w_step_last;
            n_busy           = !w_step_last;
            n_rd_idx         = w_step_nxt;
        end

        n_out.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy   <= n_busy;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: rtl/core/bdqe_check.sv
// Port-level assertion checker for the deque, bound to the top level.
`include "bounded_deque_with_erase_assert.svh"

module bdqe_check (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input bdqe_pkg::t_out i_out
);

    // a stalled result holds
    `BDQE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out))
    // every accepted item produces its first result right away
    `BDQE_ASSERT_NEXT(a_accept_result, i_clk, i_rst_n, i_in_valid && i_in_ready, i_out_valid)
    // status items are single and final
    `BDQE_ASSERT_NOW(a_status_last, i_clk, i_rst_n, i_out_valid && !i_out.is_element, i_out.last)
    // readout entries carry status ok
    `BDQE_ASSERT_NOW(a_elem_ok, i_clk, i_rst_n, i_out_valid && i_out.is_element, i_out.status == bdqe_pkg::ST_OK)
    // no new item is taken while a readout stream is unfinished
    `BDQE_ASSERT_NOW(a_stream_block, i_clk, i_rst_n, i_out_valid && i_out.is_element && !i_out.last, !i_in_ready)

endmodule

bind bounded_deque_with_erase bdqe_check u_bdqe_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);
